/* design/tmm_pkg.sv */
package tmm_pkg;

    // Q30 Taylor coefficients of sin(pi/2 * x)
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;
    localparam logic signed [33:0] Q_ONE = 34'sd1073741824;
    localparam logic signed [63:0] Q_HALF = 64'sd536870912;
    localparam int unsigned POLY_STEPS = 6;

    // Fraction bits of position, scale and matrix entries; carried untouched
    localparam int unsigned FRAC_BITS = 16;

    // Signed Q3.30 product (34 bits with sign), rounded half up
    function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = a * b + 68'(Q_HALF);
            return p[63:30];
        end
    endfunction

    // Unsigned Q30 product, rounded half up
    function automatic logic [31:0] umul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        begin
            p = {32'd0, a} * {32'd0, b} + 64'(Q_HALF);
            return p[61:30];
        end
    endfunction

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] x2;
        logic [31:0] t;
        logic        neg;
    } t_sine_lane;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_side;

endpackage

/* design/tmm_sine_cell.sv */
// One Horner step for six sine lanes at once
module tmm_sine_cell import tmm_pkg::*; #(
    parameter int unsigned STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_sine_lane [5:0]     i_lane,
    output t_sine_lane [5:0]     o_lane
);
    t_sine_lane [5:0] r_lane;
    t_sine_lane [5:0] n_lane;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_lane[i] = i_lane[i];
            unique case (STEP)
                0: n_lane[i].x2 = umul(i_lane[i].x, i_lane[i].x);
                1: n_lane[i].t  = SIN_C7 - umul(i_lane[i].x2, SIN_C9);
                2: n_lane[i].t  = SIN_C5 - umul(i_lane[i].x2, i_lane[i].t);
                3: n_lane[i].t  = SIN_C3 - umul(i_lane[i].x2, i_lane[i].t);
                4: n_lane[i].t  = SIN_C1 - umul(i_lane[i].x2, i_lane[i].t);
                default: n_lane[i].t = umul(i_lane[i].x, i_lane[i].t);
            endcase
        end
    end

    // advance when the pipe moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

/* design/trs_model_matrix.sv */
// channel | signals                                   | accepted when
// input   | i_valid, i_pos_*, i_pitch/yaw/roll, i_scale_* | i_valid && o_ready
// output  | o_valid, o_m00 .. o_m32                   | o_valid && i_ready
// One item per cycle unless stalled; data passes through the sine cell chain,
// quaternion and matrix stages. The whole pipe advances together: it stalls
// only when the output register holds an item that is not taken.
// Reset (synchronous, active low) clears the stage valid bits only.
module trs_model_matrix import tmm_pkg::*; #(
    parameter int unsigned ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [31:0]           i_pos_x,
    input  logic signed [31:0]           i_pos_y,
    input  logic signed [31:0]           i_pos_z,
    input  logic        [ANGLE_BITS-1:0] i_pitch,
    input  logic        [ANGLE_BITS-1:0] i_yaw,
    input  logic        [ANGLE_BITS-1:0] i_roll,
    input  logic signed [31:0]           i_scale_x,
    input  logic signed [31:0]           i_scale_y,
    input  logic signed [31:0]           i_scale_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_m00,
    output logic signed [31:0]           o_m01,
    output logic signed [31:0]           o_m02,
    output logic signed [31:0]           o_m10,
    output logic signed [31:0]           o_m11,
    output logic signed [31:0]           o_m12,
    output logic signed [31:0]           o_m20,
    output logic signed [31:0]           o_m21,
    output logic signed [31:0]           o_m22,
    output logic signed [31:0]           o_m30,
    output logic signed [31:0]           o_m31,
    output logic signed [31:0]           o_m32
);
    // stages: 1 setup, 6 sine cells, 1 clamp, 2 quat, 1 pair products, 1 rot, 1 scale
    localparam int unsigned NSTAGE = POLY_STEPS + 7;
    localparam int unsigned QW = ANGLE_BITS - 1;

    logic [NSTAGE-1:0] r_vld;
    logic              w_en;

    assign w_en    = !r_vld[NSTAGE-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NSTAGE-1];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_valid};
        end
    end

    // carry position and scale alongside
    t_side r_side [NSTAGE];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= '{i_pos_x, i_pos_y, i_pos_z, i_scale_x, i_scale_y, i_scale_z};
            for (int s = 1; s < NSTAGE; s++) r_side[s] <= r_side[s-1];
        end
    end

    // setup: quadrant fold per lane (sin then cos of pitch, yaw, roll)
    t_sine_lane [5:0] n_in;
    t_sine_lane [5:0] r_in;
    always_comb begin
        logic [ANGLE_BITS-1:0] ang [3];
        logic [ANGLE_BITS:0]   u;
        logic [31:0]           xf;
        ang[0] = i_pitch; ang[1] = i_yaw; ang[2] = i_roll;
        for (int i = 0; i < 6; i++) begin
            u = (i < 3) ? {1'b0, ang[i % 3]}
                        : {1'b0, ang[i % 3]} + ((ANGLE_BITS + 1)'(1) << QW);
            xf = 32'({u[QW-1:0]}) << (31 - ANGLE_BITS);
            n_in[i].x   = u[QW] ? (32'(Q_ONE) - xf) : xf;
            n_in[i].x2  = '0;
            n_in[i].t   = '0;
            n_in[i].neg = u[QW+1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_in <= n_in;
    end

    // chain of Horner cells
    t_sine_lane [5:0] w_chain [POLY_STEPS+1];
    assign w_chain[0] = r_in;
    genvar g;
    generate
        for (g = 0; g < POLY_STEPS; g++) begin : g_cell
            tmm_sine_cell #(.STEP(g)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_lane(w_chain[g]),
                .o_lane(w_chain[g+1])
            );
        end
    endgenerate

    // clamp and sign
    logic signed [33:0] r_sn [3];
    logic signed [33:0] r_cs [3];
    always_ff @(posedge i_clk) begin
        logic [31:0] s;
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                s = w_chain[POLY_STEPS][i].t;
                if (s > 32'(Q_ONE)) s = 32'(Q_ONE);
                if (i < 3) r_sn[i] <= w_chain[POLY_STEPS][i].neg ? -$signed({2'b0, s})
                                                                 : $signed({2'b0, s});
                else r_cs[i-3] <= w_chain[POLY_STEPS][i].neg ? -$signed({2'b0, s})
                                                             : $signed({2'b0, s});
            end
        end
    end

    // quaternion first products
    logic signed [33:0] r_cc, r_ss, r_sc, r_cs1, r_c2, r_s2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc  <= qmul(r_cs[0], r_cs[1]);
            r_ss  <= qmul(r_sn[0], r_sn[1]);
            r_sc  <= qmul(r_sn[0], r_cs[1]);
            r_cs1 <= qmul(r_cs[0], r_sn[1]);
            r_c2  <= r_cs[2];
            r_s2  <= r_sn[2];
        end
    end

    // quaternion components
    logic signed [33:0] r_w, r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w <= qmul(r_cc, r_c2) + qmul(r_ss, r_s2);
            r_x <= qmul(r_sc, r_c2) - qmul(r_cs1, r_s2);
            r_y <= qmul(r_cs1, r_c2) + qmul(r_sc, r_s2);
            r_z <= qmul(r_cc, r_s2) - qmul(r_ss, r_c2);
        end
    end

    // pair products
    logic signed [33:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xx <= qmul(r_x, r_x); r_yy <= qmul(r_y, r_y); r_zz <= qmul(r_z, r_z);
            r_xy <= qmul(r_x, r_y); r_xz <= qmul(r_x, r_z); r_yz <= qmul(r_y, r_z);
            r_wx <= qmul(r_w, r_x); r_wy <= qmul(r_w, r_y); r_wz <= qmul(r_w, r_z);
        end
    end

    // rotation entries
    logic signed [35:0] r_rot [9];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rot[0] <= 36'(Q_ONE) - 36'(r_yy + r_zz) * 2;
            r_rot[1] <= 36'(r_xy + r_wz) * 2;
            r_rot[2] <= 36'(r_xz - r_wy) * 2;
            r_rot[3] <= 36'(r_xy - r_wz) * 2;
            r_rot[4] <= 36'(Q_ONE) - 36'(r_xx + r_zz) * 2;
            r_rot[5] <= 36'(r_yz + r_wx) * 2;
            r_rot[6] <= 36'(r_xz + r_wy) * 2;
            r_rot[7] <= 36'(r_yz - r_wx) * 2;
            r_rot[8] <= 36'(Q_ONE) - 36'(r_xx + r_yy) * 2;
        end
    end

    // scale, round and saturate
    logic signed [31:0] r_m [9];
    always_ff @(posedge i_clk) begin
        logic signed [67:0] p;
        logic signed [37:0] v;
        logic signed [31:0] sc;
        if (w_en) begin
            for (int i = 0; i < 9; i++) begin
                sc = (i < 3) ? r_side[NSTAGE-2].scale_x :
                     (i < 6) ? r_side[NSTAGE-2].scale_y : r_side[NSTAGE-2].scale_z;
                p = r_rot[i] * sc + 68'(Q_HALF);
                v = p[67:30];
                if (v > 38'sd2147483647) r_m[i] <= 32'sh7FFFFFFF;
                else if (v < -38'sd2147483648) r_m[i] <= 32'sh80000000;
                else r_m[i] <= v[31:0];
            end
        end
    end

    assign o_m00 = r_m[0]; assign o_m01 = r_m[1]; assign o_m02 = r_m[2];
    assign o_m10 = r_m[3]; assign o_m11 = r_m[4]; assign o_m12 = r_m[5];
    assign o_m20 = r_m[6]; assign o_m21 = r_m[7]; assign o_m22 = r_m[8];
    assign o_m30 = r_side[NSTAGE-1].pos_x;
    assign o_m31 = r_side[NSTAGE-1].pos_y;
    assign o_m32 = r_side[NSTAGE-1].pos_z;
endmodule
